// ----- design/block_bitmap_allocator_assert.svh -----
// Assertion macros for the block bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define BBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define BBA_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BBA_ASSERT(name, prop, msg)
`define BBA_ASSERT_RST(name, prop, msg)
`endif
`endif

// ----- design/bba_pkg.sv -----
// Shared types and constants of the block bitmap allocator.
package bba_pkg;

  localparam int BLK_W      = 16;  // block numbers and the reserved and root registers
  localparam int TOT_W      = 17;  // block counts, up to and including 65536
  localparam int PW         = TOT_W + 1;  // scan position, room for one word past the end
  localparam int ACT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - BLK_W;

  localparam logic [BLK_W-1:0] RESERVED_RST = 16'd2;
  localparam logic [TOT_W-1:0] TOTAL_RST    = 17'd1760;
  localparam logic [BLK_W-1:0] ROOT_RST     = 16'd880;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_NEXT  = 2'd2,
    ACT_TEST  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_USED  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESERVED = 2'd0,
    CFG_TOTAL    = 2'd1,
    CFG_ROOT     = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CK,
    S_PICK,
    S_RESP
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic    fill_clr;     // restart the fill sweep
    logic    fill_wr;      // write one all-ones word
    logic    latch;        // capture the incoming request
    logic    setup;        // range checks and scan bounds
    logic    rd_item;      // read the word of the addressed block
    logic    claim;        // clear the addressed bit
    logic    scan_start2;  // begin the wrap pass
    logic    scan_rd;      // read the word at the scan position
    logic    scan_next;    // advance to the next word
    logic    scan_hit;     // keep the word that holds a free bit
    logic    pick;         // claim the first free bit of the kept word
    logic    set_status;
    status_e status;
    logic    out_load;     // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    action_e in_act;     // action of the request on the input bus
    action_e act;        // action of the request in progress
    logic    fill_last;
    logic    in_range;
    logic    bit_free;
    logic    scan_end;
    logic    pass2;
    logic    word_hit;
  } sts_t;

endpackage

// ----- design/bba_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module bba_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bba_ctrl.sv -----
// Controller state machine of the block bitmap allocator.
`include "block_bitmap_allocator_assert.svh"

module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   init_pend_q, init_pend_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    init_pend_d = init_pend_q;
    unique case (state_q)
      S_FILL: begin
        if (sts_i.fill_last) begin
          state_d     = init_pend_q ? S_SETUP : S_IDLE;
          init_pend_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          if (sts_i.in_act == ACT_INIT) begin
            state_d     = S_FILL;
            init_pend_d = 1'b1;
          end else begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP:   state_d = (sts_i.act == ACT_NEXT) ? S_SCAN_RD : S_READ;
      S_READ:    state_d = sts_i.in_range ? S_CHECK : S_RESP;
      S_CHECK:   state_d = S_RESP;
      S_SCAN_RD: begin
        if (!sts_i.scan_end) begin
          state_d = S_SCAN_CK;
        end else if (sts_i.pass2) begin
          state_d = S_RESP;
        end
      end
      S_SCAN_CK: state_d = sts_i.word_hit ? S_PICK : S_SCAN_RD;
      S_PICK:    state_d = S_RESP;
      S_RESP:    state_d = out_free ? S_IDLE : S_RESP;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ST_OK;
    s_ready_o    = 1'b0;
    unique case (state_q)
      S_FILL:  cmd_o.fill_wr = 1'b1;
      S_IDLE: begin
        s_ready_o      = 1'b1;
        cmd_o.latch    = s_valid_i;
        cmd_o.fill_clr = s_valid_i && (sts_i.in_act == ACT_INIT);
      end
      S_SETUP: cmd_o.setup = 1'b1;
      S_READ: begin
        if (sts_i.in_range) begin
          cmd_o.rd_item = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_RANGE;
        end
      end
      S_CHECK: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.bit_free) begin
          cmd_o.status = ST_OK;
          cmd_o.claim  = (sts_i.act != ACT_TEST);
        end else begin
          cmd_o.status = ST_USED;
        end
      end
      S_SCAN_RD: begin
        if (!sts_i.scan_end) begin
          cmd_o.scan_rd = 1'b1;
        end else if (!sts_i.pass2) begin
          cmd_o.scan_start2 = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NONE;
        end
      end
      S_SCAN_CK: begin
        cmd_o.scan_hit  = sts_i.word_hit;
        cmd_o.scan_next = !sts_i.word_hit;
      end
      S_PICK: begin
        cmd_o.pick       = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_OK;
      end
      S_RESP:  cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      init_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_pend_q <= init_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

  `BBA_ASSERT_RST(a_reset_fill, !rst_ni |-> (state_q == S_FILL && !out_valid_q), "reset state wrong")
  `BBA_ASSERT(a_no_overwrite, (out_valid_q && !m_ready_i) |-> !cmd_o.out_load, "result overwritten")
  `BBA_ASSERT(a_accept_path, (state_q == S_IDLE && s_valid_i) |=> (state_q == S_FILL || state_q == S_SETUP), "request lost after acceptance")
  `BBA_ASSERT(a_one_wrap, (state_q == S_SCAN_RD && sts_i.scan_end && sts_i.pass2) |=> (state_q == S_RESP), "search did not end after the wrap pass")

endmodule

// ----- design/bba_dpath.sv -----
// Datapath of the block bitmap allocator: registers, bitmap memory and search logic.
module bba_dpath
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  output logic [OUT_DATA_W-1:0] m_data_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  // The word width must be a power of two, which is not checked here; word and bit split by slicing.
  localparam int WB    = MAP_WORD_BITS;
  localparam int LB    = $clog2(WB);
  localparam int WORDS = (MAX_BLOCKS + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW    = (LB + AW > PW) ? LB + AW : PW;
  localparam int MB_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (MB_W > TOT_W) ? MB_W : TOT_W;

  logic [BLK_W-1:0] reserved_q, root_q, cursor_q;
  logic [TOT_W-1:0] total_q, eff_q;
  action_e          act_q;
  logic [BLK_W-1:0] blk_q;
  logic             in_range_q;
  logic [TOT_W-1:0] rel_q, last_q, wrap_q;
  logic [PW-1:0]    p_q, hi_q;
  logic             pass2_q;
  logic [LB-1:0]    off_q, lim_q;
  logic             lim_all_q;
  logic [WB-1:0]    word_q, hit_q;
  logic [AW-1:0]    fill_q;
  status_e          status_q;
  logic [BLK_W-1:0] result_q, out_result_q;
  status_e          out_status_q;

  logic [WB-1:0]    ram_rdata, ram_wdata, scan_mask;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic             ram_we;
  logic [BLK_W-1:0] tgt;
  logic [PW-1:0]    base, span, pick_rel;
  logic [CW-1:0]    tot_ext;
  logic [LB-1:0]    pick_bit;

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] r);
    logic [XW-1:0] e;
    e = XW'(r);
    return e[LB +: AW];
  endfunction

  // Index of the lowest set bit, found by halving the word.
  function automatic logic [LB-1:0] first_set(logic [WB-1:0] w);
    logic [WB-1:0] v;
    logic [LB-1:0] idx;
    v   = w;
    idx = '0;
    for (int lvl = LB - 1; lvl >= 0; lvl--) begin
      if ((v & ((WB'(1) << (1 << lvl)) - WB'(1))) == '0) begin
        idx[lvl] = 1'b1;
        v        = v >> (1 << lvl);
      end
    end
    return idx;
  endfunction

  // Volume size clamped to what the bitmap can hold.
  assign tot_ext = CW'(total_q);

  always_ff @(posedge clk_i) begin
    eff_q <= TOT_W'((tot_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : tot_ext);
  end

  assign tgt      = (act_q == ACT_INIT) ? root_q : blk_q;
  assign base     = p_q & ~PW'(WB - 1);
  assign span     = hi_q - base;
  assign pick_bit = first_set(hit_q);
  assign pick_rel = base | PW'(pick_bit);

  assign scan_mask = ram_rdata & ({WB{1'b1}} << off_q)
                   & (lim_all_q ? {WB{1'b1}} : ~({WB{1'b1}} << lim_q));

  // Bitmap memory port selection.
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = fill_q;
    ram_wdata = {WB{1'b1}};
    if (cmd_i.fill_wr) begin
      ram_waddr = fill_q;
      ram_wdata = {WB{1'b1}};
    end else if (cmd_i.claim) begin
      ram_waddr = addr_of(PW'(rel_q));
      ram_wdata = ram_rdata & ~(WB'(1) << rel_q[LB-1:0]);
    end else if (cmd_i.pick) begin
      ram_waddr = addr_of(p_q);
      ram_wdata = word_q & ~(WB'(1) << pick_bit);
    end else begin
      ram_we = 1'b0;
    end
  end

  assign ram_raddr = cmd_i.rd_item ? addr_of(PW'(rel_q)) : addr_of(p_q);

  bba_ram #(
    .WIDTH(WB),
    .DEPTH(WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration, cursor and fill counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= RESERVED_RST;
      total_q    <= TOTAL_RST;
      root_q     <= ROOT_RST;
      cursor_q   <= '0;
      fill_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RESERVED: reserved_q <= cfg_wdata_i[BLK_W-1:0];
          CFG_TOTAL:    total_q    <= cfg_wdata_i[TOT_W-1:0];
          CFG_ROOT:     root_q     <= cfg_wdata_i[BLK_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.fill_clr) begin
        fill_q <= '0;
      end else if (cmd_i.fill_wr) begin
        fill_q <= fill_q + AW'(1);
      end
      if (cmd_i.setup && act_q == ACT_INIT) begin
        cursor_q <= root_q;
      end else if (cmd_i.pick) begin
        cursor_q <= BLK_W'(pick_rel + PW'(reserved_q));
      end
    end
  end

  // Request, search and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_e'(s_data_i[ACT_W-1:0]);
      blk_q <= s_data_i[ACT_W +: BLK_W];
    end
    if (cmd_i.setup) begin
      in_range_q <= (tgt >= reserved_q) && (TOT_W'(tgt) < eff_q);
      rel_q      <= TOT_W'(tgt) - TOT_W'(reserved_q);
      last_q     <= (eff_q > TOT_W'(reserved_q)) ? eff_q - TOT_W'(reserved_q) : '0;
      wrap_q     <= (root_q > reserved_q) ? TOT_W'(root_q - reserved_q) : '0;
      p_q        <= (cursor_q > reserved_q) ? PW'(cursor_q - reserved_q) : '0;
      hi_q       <= (eff_q > TOT_W'(reserved_q)) ? PW'(eff_q - TOT_W'(reserved_q)) : '0;
      pass2_q    <= 1'b0;
      result_q   <= '0;
    end
    if (cmd_i.scan_start2) begin
      p_q     <= '0;
      hi_q    <= PW'((wrap_q > last_q) ? last_q : wrap_q);
      pass2_q <= 1'b1;
    end
    if (cmd_i.scan_rd) begin
      off_q     <= p_q[LB-1:0];
      lim_q     <= span[LB-1:0];
      lim_all_q <= (span >= PW'(WB));
    end
    if (cmd_i.scan_next) begin
      p_q <= base + PW'(WB);
    end
    if (cmd_i.scan_hit) begin
      hit_q  <= scan_mask;
      word_q <= ram_rdata;
    end
    if (cmd_i.pick) begin
      result_q <= BLK_W'(pick_rel + PW'(reserved_q));
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_result_q <= result_q;
    end
  end

  assign m_data_o = {{OUT_PAD_W{1'b0}}, out_result_q, out_status_q};

  assign sts_o.in_act    = action_e'(s_data_i[ACT_W-1:0]);
  assign sts_o.act       = act_q;
  assign sts_o.fill_last = (fill_q == AW'(WORDS - 1));
  assign sts_o.in_range  = in_range_q;
  assign sts_o.bit_free  = ram_rdata[rel_q[LB-1:0]];
  assign sts_o.scan_end  = (p_q >= hi_q);
  assign sts_o.pass2     = pass2_q;
  assign sts_o.word_hit  = |scan_mask;

endmodule

// ----- design/block_bitmap_allocator.sv -----
// Top level of the free-block bitmap allocator with next-fit search.
//
// Requests arrive on the s_axis stream, one transaction per request, and each
// request yields exactly one transaction on the m_axis stream carrying a status
// and, for allocate-next, the claimed block number. The three volume registers
// (reserved area size, total blocks, root block) are to be written through the
// cfg port only while no request is in flight; the block does not enforce this.
// They take effect for the next request. Allocate-given and test go through
// range check, registered read of the bitmap word, bit check and write-back, and
// result load; a block out of range skips the read and the bit check.
// Allocate-next reads and checks the bitmap one word at a time, one memory read
// per word, through the pass from the cursor and, if that finds nothing, the wrap
// pass. Init rewrites the whole bitmap, one word per cycle, then claims the root
// block.
// A new request is accepted at the edge after the previous result is loaded into
// the output register, even if the receiver has not taken it. After reset the same
// clearing pass runs and s_axis_tready_o stays low until it ends. A stalled
// receiver holds the result in place, and a finished request waits for the output
// register to free up before the block returns to accepting requests.
// MAP_WORD_BITS must be a power of two.
module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Request stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // action [1:0], block_number [17:2]
  // Result stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // status [1:0], result_block [17:2]
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of fills, checks and the word-by-word search.
  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Volume registers, bitmap memory, cursor and output payload.
  bba_dpath #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_data_i    (s_axis_tdata_i),
    .m_data_o    (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- dv/block_bitmap_allocator_tb.sv -----
// Self-checking testbench of the block bitmap allocator: directed plan, then random phases.
module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned VOLUME_MAX   = 65536;
  localparam int unsigned RANDOM_ITEMS = 1370;

  typedef struct packed {
    status_e     st;
    logic [15:0] blk;
  } reply_t;

  // A reply typed into the plan; known is low where the predictor decides.
  typedef struct packed {
    bit          known;
    status_e     st;
    logic [15:0] blk;
  } pinned_t;

  // One row of the directed plan: a register write or a request.
  typedef struct packed {
    bit          cfg;
    cfg_reg_e    idx;
    logic [16:0] val;
    action_e     act;
    logic [15:0] blk;
    bit          known;
    status_e     st;
    logic [15:0] res;
  } plan_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b1;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // action [1:0], block_number [17:2]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // status [1:0], result_block [17:2]

  block_bitmap_allocator DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #1 clk_i = ~clk_i;

  // Percent of cycles in which the request side holds back and the result side stalls.
  int unsigned src_idle_pct  = 20;
  int unsigned sink_idle_pct = 68;
  int unsigned mismatches    = 0;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Predictor state: relative bit r stands for block r + reserved, 1 means free.
  bit          free_bits [VOLUME_MAX];
  logic [15:0] cursor_blk   = '0;
  logic [15:0] reg_reserved = RESERVED_RST;
  logic [16:0] reg_total    = TOTAL_RST;
  logic [15:0] reg_root     = ROOT_RST;

  reply_t  replies_due    [$];
  pinned_t pinned_replies [$];

  function automatic int unsigned volume_end();
    return (reg_total > VOLUME_MAX) ? VOLUME_MAX : int'(reg_total);
  endfunction

  function automatic status_e claim_block(logic [15:0] blk, bit take);
    int unsigned rel;
    if (blk < reg_reserved || blk >= volume_end()) return ST_RANGE;
    rel = blk - reg_reserved;
    if (!free_bits[rel]) return ST_USED;
    if (take) free_bits[rel] = 1'b0;
    return ST_OK;
  endfunction

  function automatic bit first_free(int unsigned lo, int unsigned hi,
                                    output int unsigned rel);
    rel = 0;
    for (int unsigned r = lo; r < hi; r++) begin
      if (free_bits[r]) begin
        rel = r;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the reply to one request and updates the map, cursor included.
  function automatic void serve_request(input action_e act, input logic [15:0] blk,
                                        output status_e st, output logic [15:0] got);
    int unsigned vol, tracked, start, wrap_end, rel;
    bit          hit;
    st  = ST_OK;
    got = '0;
    case (act)
      ACT_INIT: begin
        foreach (free_bits[i]) free_bits[i] = 1'b1;
        st         = claim_block(reg_root, 1'b1);
        cursor_blk = reg_root;
      end
      ACT_ALLOC: st = claim_block(blk, 1'b1);
      ACT_NEXT: begin
        vol      = volume_end();
        tracked  = (vol > reg_reserved) ? vol - reg_reserved : 0;
        start    = (cursor_blk > reg_reserved) ? cursor_blk - reg_reserved : 0;
        wrap_end = (reg_root > reg_reserved) ? reg_root - reg_reserved : 0;
        if (wrap_end > tracked) wrap_end = tracked;
        // Next fit: cursor up to the end, then one pass from the bottom up to the root.
        hit = first_free(start, tracked, rel);
        if (!hit) hit = first_free(0, wrap_end, rel);
        if (hit) begin
          free_bits[rel] = 1'b0;
          got            = 16'(rel + reg_reserved);
          cursor_blk     = got;
        end else begin
          st = ST_NONE;
        end
      end
      default: st = claim_block(blk, 1'b0);
    endcase
  endfunction

  // Everything is sampled at the rising edge, so all values seen are those before the edge.
  always @(posedge clk_i) begin : scoreboard
    reply_t      want;
    pinned_t     pin;
    status_e     st;
    logic [15:0] got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RESERVED: reg_reserved = cfg_wdata_i[15:0];
          CFG_TOTAL:    reg_total    = cfg_wdata_i;
          CFG_ROOT:     reg_root     = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d block %0d", $time,
                   m_axis_tdata_o[1:0], m_axis_tdata_o[17:2]);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata_o[1:0] !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st,
                     m_axis_tdata_o[1:0]);
            mismatches++;
          end
          if (m_axis_tdata_o[17:2] !== want.blk) begin
            $display("%0t: result block expected %0d actual %0d", $time, want.blk,
                     m_axis_tdata_o[17:2]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        serve_request(action_e'(s_axis_tdata_i[1:0]), s_axis_tdata_i[17:2], st, got);
        if (pinned_replies.size() != 0) begin
          pin = pinned_replies.pop_front();
          if (pin.known) begin
            st  = pin.st;
            got = pin.blk;
          end
        end
        replies_due.push_back('{st, got});
      end
    end
  end

  // Offers one request and returns at the edge where its transaction completes.
  // Valid stays high afterwards, so back-to-back requests need no extra edge.
  task automatic issue_request(input action_e act, input logic [15:0] blk,
                               input bit known, input status_e st, input logic [15:0] res);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    pinned_replies.push_back('{known, st, res});
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, blk, act};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stops offering requests and waits until every reply has come back.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [16:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Directed plan. It starts on the reset volume (2 reserved, 1760 total, root 880)
  // and then walks through tiny volumes for the corner cases.
  plan_row_t directed_plan [35] = '{
    // Fresh map, cursor at zero, which lies below the reserved area.
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'd880,   1'b1, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'hFFFF,  1'b1, ST_OK,    16'd2},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'd2,     1'b1, ST_USED,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_ALLOC, 16'd0,     1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_ALLOC, 16'd1760,  1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_ALLOC, 16'd1759,  1'b1, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_ALLOC, 16'd1759,  1'b1, ST_USED,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'hFFFF,  1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_INIT,  16'hFFFF,  1'b1, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'd880,   1'b1, ST_USED,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b0, ST_OK,    16'd0},
    // Root inside the reserved area: init reports a range error.
    '{1'b1, CFG_ROOT,     17'd1, ACT_INIT,  16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_INIT,  16'd0,     1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b0, ST_OK,    16'd0},
    // Two tracked blocks (10 and 11) with the root below them: the wrap pass is empty.
    '{1'b1, CFG_RESERVED, 17'd10, ACT_INIT, 16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b1, CFG_TOTAL,    17'd12, ACT_INIT, 16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b1, CFG_ROOT,     17'd0, ACT_INIT,  16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_INIT,  16'd0,     1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_OK,    16'd10},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_OK,    16'd11},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_NONE,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'd11,    1'b1, ST_USED,  16'd0},
    // Root past the end: the first pass is empty and the wrap pass covers the volume.
    '{1'b1, CFG_ROOT,     17'd20, ACT_INIT, 16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_INIT,  16'd0,     1'b1, ST_RANGE, 16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_OK,    16'd10},
    // Reserved area reaching the end of the volume: nothing can be allocated.
    '{1'b1, CFG_RESERVED, 17'd12, ACT_INIT, 16'd0,     1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_NONE,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_TEST,  16'd11,    1'b1, ST_RANGE, 16'd0},
    // Total beyond the volume limit, one tracked block which is also the root.
    '{1'b1, CFG_RESERVED, 17'd65535, ACT_INIT, 16'd0,  1'b0, ST_OK,    16'd0},
    '{1'b1, CFG_TOTAL,    17'h1FFFF, ACT_INIT, 16'd0,  1'b0, ST_OK,    16'd0},
    '{1'b1, CFG_ROOT,     17'd65535, ACT_INIT, 16'd0,  1'b0, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_INIT,  16'd0,     1'b1, ST_OK,    16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_NEXT,  16'd0,     1'b1, ST_NONE,  16'd0},
    '{1'b0, CFG_RESERVED, 17'd0, ACT_ALLOC, 16'hFFFF,  1'b1, ST_USED,  16'd0}
  };

  initial begin : stimulus
    int unsigned issued, n_items, span, vol, pick;
    logic [15:0] rsv, root, blk;
    logic [16:0] tot;
    action_e     act;
    rst_ni <= 1'b0;
    foreach (free_bits[i]) free_bits[i] = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].cfg) begin
        drain();
        write_reg(directed_plan[k].idx, directed_plan[k].val);
      end else begin
        issue_request(directed_plan[k].act, directed_plan[k].blk, directed_plan[k].known,
                      directed_plan[k].st, directed_plan[k].res);
      end
    end

    // Random phases: each one sets a new volume while idle, usually formats it, and then
    // runs a request mix centered on the tracked blocks so that volumes fill up and wrap.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      drain();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        rsv     = RESERVED_RST;
        tot     = TOTAL_RST;
        root    = ROOT_RST;
        n_items = $urandom_range(20, 50);
      end else if (pick == 1) begin
        // Full-size volume; kept short since a miss would scan the whole map.
        rsv     = 16'($urandom_range(0, 3));
        tot     = $urandom_range(0, 1) ? 17'd65536 : 17'h1FFFF;
        root    = 16'($urandom);
        n_items = $urandom_range(5, 15);
      end else if (pick == 2) begin
        // Nothing tracked at all.
        tot     = 17'($urandom_range(0, 300));
        rsv     = 16'(tot + $urandom_range(0, 2));
        root    = 16'($urandom_range(0, 400));
        n_items = $urandom_range(4, 10);
      end else begin
        rsv  = 16'($urandom);
        span = $urandom_range(1, $urandom_range(0, 1) ? 16 : 200);
        tot  = 17'(rsv + span);
        case ($urandom_range(0, 3))
          0:       root = 16'($urandom_range(0, rsv));
          1:       root = 16'(rsv + $urandom_range(0, span - 1));
          2:       root = 16'(tot + $urandom_range(0, 40));
          default: root = 16'($urandom);
        endcase
        n_items = $urandom_range(15, 60);
      end
      write_reg(CFG_RESERVED, 17'(rsv));
      write_reg(CFG_TOTAL, tot);
      write_reg(CFG_ROOT, 17'(root));
      vol  = (tot > VOLUME_MAX) ? VOLUME_MAX : 32'(tot);
      span = (vol > rsv) ? vol - rsv : 0;

      if ($urandom_range(0, 9) != 0) issue_request(ACT_INIT, 16'($urandom), 1'b0, ST_OK, '0);
      repeat (n_items) begin
        // Idling pattern by thirds: slow receiver, then slow sender, then full speed.
        if (issued < RANDOM_ITEMS / 3) begin
          src_idle_pct  = 20;
          sink_idle_pct = 68;
        end else if (issued < 2 * RANDOM_ITEMS / 3) begin
          src_idle_pct  = 68;
          sink_idle_pct = 20;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        pick = $urandom_range(0, 99);
        blk  = 16'($urandom);
        if (span != 0 && pick >= 45 && pick < 85) blk = 16'(rsv + $urandom_range(0, span - 1));
        if (pick < 45)      act = ACT_NEXT;
        else if (pick < 70) act = ACT_ALLOC;
        else if (pick < 85) act = ACT_TEST;
        else if (pick < 97) act = $urandom_range(0, 1) ? ACT_ALLOC : ACT_TEST;
        else                act = ACT_INIT;
        issue_request(act, blk, 1'b0, ST_OK, '0);
        issued++;
      end
    end

    drain();
    // Keep waiting so that any stray result after the last one would still show up.
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS block_bitmap_allocator");
    end else begin
      $display("FAIL block_bitmap_allocator");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("FAIL block_bitmap_allocator");
    $finish;
  end

endmodule

// ----- block_bitmap_allocator.f -----
+incdir+design
design/bba_pkg.sv
design/bba_ram.sv
design/bba_ctrl.sv
design/bba_dpath.sv
design/block_bitmap_allocator.sv
dv/block_bitmap_allocator_tb.sv
